// ----- design/cwte_pkg.sv -----
// ----------------------------------------------------------------------------
// cwte_pkg: shared types and constants for the code word table encoder
// Command codes, register indexes, code bases and the control/status bundles
// that join the sequencer and the datapath.
// ----------------------------------------------------------------------------
package cwte_pkg;

   localparam int TableEntriesDef = 1792;
   localparam int IdxW            = 11;
   localparam int WordW           = 32;
   localparam int PrefixW         = 24;
   localparam int EmitDepth       = 9;

   localparam logic [11:0] FULL_BASE = 12'h900;
   localparam logic [11:0] PRE_BASE  = 12'h200;
   localparam logic [3:0]  TOP_NIB   = 4'h0;
   localparam logic [3:0]  LIT_NIB   = 4'h1;
   localparam logic [3:0]  PAD_NIB   = 4'h0;

   typedef enum logic [1:0] {
      CMD_ENCODE    = 2'd0,
      CMD_LOAD_FULL = 2'd1,
      CMD_LOAD_PRE  = 2'd2,
      CMD_END       = 2'd3
   } cmd_type;

   localparam logic [1:0] REG_TOP_VALUE    = 2'd0;
   localparam logic [1:0] REG_FULL_COUNT   = 2'd1;
   localparam logic [1:0] REG_PREFIX_COUNT = 2'd2;
   localparam logic [1:0] REG_BYTE_SWAP    = 2'd3;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic wr_full;
      logic wr_pre;
      logic capture;
      logic start_full;
      logic start_pre;
      logic step;
      logic set_top;
      logic set_full;
      logic set_pre;
      logic set_lit;
      logic set_none;
      logic finish;
      logic pop;
   } ctl_type;

   // Status from the datapath to the sequencer.
   typedef struct packed {
      logic top_eq;
      logic hit;
      logic miss;
      logic pair_half;
      logic out_free;
      logic last_byte;
   } stat_type;

endpackage

// ----- design/cwte_ctrl.sv -----
// ----------------------------------------------------------------------------
// cwte_ctrl: sequencer of the code word table encoder
// Writes table loads directly and walks each encode beat through capture,
// top-value check, the two table searches, pairing and byte emission.
// ----------------------------------------------------------------------------
module cwte_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  cwte_pkg::cmd_type  req_command,
   output logic               req_tready,
   input  cwte_pkg::stat_type stat,
   output cwte_pkg::ctl_type  ctl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASS,
      ST_SFULL,
      ST_SPRE,
      ST_FIN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff;
   logic      accept;

   assign accept     = req_tvalid && ready_ff;
   assign req_tready = ready_ff;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  cwte_pkg::CMD_LOAD_FULL: ctl.wr_full = 1'b1;
                  cwte_pkg::CMD_LOAD_PRE:  ctl.wr_pre  = 1'b1;
                  cwte_pkg::CMD_END: begin
                     if (stat.pair_half) begin
                        ctl.set_none = 1'b1;
                        state_in     = ST_FIN;
                     end
                  end
                  cwte_pkg::CMD_ENCODE: begin
                     ctl.capture = 1'b1;
                     state_in    = ST_CLASS;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLASS: begin
            if (stat.top_eq) begin
               ctl.set_top = 1'b1;
               state_in    = ST_FIN;
            end else begin
               ctl.start_full = 1'b1;
               state_in       = ST_SFULL;
            end
         end
         ST_SFULL: begin
            if (stat.hit) begin
               ctl.set_full = 1'b1;
               state_in     = ST_FIN;
            end else if (stat.miss) begin
               ctl.start_pre = 1'b1;
               state_in      = ST_SPRE;
            end else begin
               ctl.step = 1'b1;
            end
         end
         ST_SPRE: begin
            if (stat.hit) begin
               ctl.set_pre = 1'b1;
               state_in    = ST_FIN;
            end else if (stat.miss) begin
               ctl.set_lit = 1'b1;
               state_in    = ST_FIN;
            end else begin
               ctl.step = 1'b1;
            end
         end
         ST_FIN: begin
            ctl.finish = 1'b1;
            state_in   = stat.pair_half ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               ctl.pop = 1'b1;
               if (stat.last_byte) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == ST_IDLE);
      end
   end

endmodule

// ----- design/cwte_dp.sv -----
// ----------------------------------------------------------------------------
// cwte_dp: datapath of the code word table encoder
// Configuration registers, the two sorted tables, the binary search
// registers, the pair holding registers and the byte output register.
// ----------------------------------------------------------------------------
module cwte_dp #(
   parameter int TableEntries = cwte_pkg::TableEntriesDef
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [1:0]                   csr_addr,
   input  logic [cwte_pkg::WordW-1:0]   csr_wr_data,
   input  logic [cwte_pkg::WordW-1:0]   word,
   input  logic [cwte_pkg::IdxW-1:0]    entry_index,
   input  cwte_pkg::ctl_type            ctl,
   output cwte_pkg::stat_type           stat,
   input  logic                         rsp_tready,
   output logic                         rsp_tvalid,
   output logic [7:0]                   rsp_byte,
   output logic                         rsp_last
);

   localparam int CntW  = $clog2(TableEntries + 1);
   localparam int AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

   // Configuration.
   logic [cwte_pkg::WordW-1:0] top_ff;
   logic [cwte_pkg::IdxW-1:0]  full_cnt_ff;
   logic [cwte_pkg::IdxW-1:0]  pre_cnt_ff;
   logic                       swap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff      <= '0;
         full_cnt_ff <= '0;
         pre_cnt_ff  <= '0;
         swap_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            cwte_pkg::REG_TOP_VALUE:    top_ff      <= csr_wr_data;
            cwte_pkg::REG_FULL_COUNT:   full_cnt_ff <= csr_wr_data[cwte_pkg::IdxW-1:0];
            cwte_pkg::REG_PREFIX_COUNT: pre_cnt_ff  <= csr_wr_data[cwte_pkg::IdxW-1:0];
            cwte_pkg::REG_BYTE_SWAP:    swap_ff     <= csr_wr_data[0];
            default:                    swap_ff     <= swap_ff;
         endcase
      end
   end

   // Tables: one write port and one registered read port each.
   logic [cwte_pkg::WordW-1:0]   full_mem [TableEntries];
   logic [cwte_pkg::PrefixW-1:0] pre_mem  [TableEntries];
   logic [cwte_pkg::WordW-1:0]   full_rd_ff;
   logic [cwte_pkg::PrefixW-1:0] pre_rd_ff;
   logic                         idx_ok;

   logic [CntW-1:0] lo_ff, hi_ff, mid_ff;
   logic [CntW-1:0] lo_in, hi_in, mid_in;
   logic [CntW:0]   mid_sum;

   assign idx_ok = entry_index < cwte_pkg::IdxW'(TableEntries);

   always_ff @(posedge clock) begin
      if (ctl.wr_full && idx_ok) begin
         full_mem[entry_index[AddrW-1:0]] <= word;
      end
      if (ctl.wr_pre && idx_ok) begin
         pre_mem[entry_index[AddrW-1:0]] <= word[cwte_pkg::PrefixW-1:0];
      end
      full_rd_ff <= full_mem[mid_in[AddrW-1:0]];
      pre_rd_ff  <= pre_mem[mid_in[AddrW-1:0]];
   end

   // Captured word and search.
   logic [cwte_pkg::WordW-1:0] key_ff;
   logic                       sel_pre_ff;
   logic                       active;
   logic                       probe_eq;
   logic                       probe_lt;
   logic [CntW-1:0]            full_lim;
   logic [CntW-1:0]            pre_lim;

   assign full_lim = (full_cnt_ff > cwte_pkg::IdxW'(TableEntries)) ?
                     CntW'(TableEntries) : CntW'(full_cnt_ff);
   assign pre_lim  = (pre_cnt_ff > cwte_pkg::IdxW'(TableEntries)) ?
                     CntW'(TableEntries) : CntW'(pre_cnt_ff);

   assign active   = lo_ff < hi_ff;
   assign probe_eq = sel_pre_ff ? (pre_rd_ff == key_ff[cwte_pkg::WordW-1:8])
                                : (full_rd_ff == key_ff);
   assign probe_lt = sel_pre_ff ? (pre_rd_ff < key_ff[cwte_pkg::WordW-1:8])
                                : (full_rd_ff < key_ff);

   // The next probe address goes straight to the tables so that one probe
   // is compared in every cycle.
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (ctl.start_full) begin
         lo_in = '0;
         hi_in = full_lim;
      end else if (ctl.start_pre) begin
         lo_in = '0;
         hi_in = pre_lim;
      end else if (ctl.step && active && !probe_eq) begin
         if (probe_lt) begin
            lo_in = mid_ff + CntW'(1);
         end else begin
            hi_in = mid_ff;
         end
      end
      mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
      mid_in  = mid_sum[CntW:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff  <= '0;
         hi_ff  <= '0;
         mid_ff <= '0;
      end else begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         key_ff <= swap_ff ? {word[7:0], word[15:8], word[23:16], word[31:24]} : word;
      end
      if (ctl.start_full) begin
         sel_pre_ff <= 1'b0;
      end else if (ctl.start_pre) begin
         sel_pre_ff <= 1'b1;
      end
   end

   // Code of the current word.
   logic [3:0]  cur_nib_ff;
   logic [7:0]  cur_b_ff [4];
   logic [2:0]  cur_nb_ff;
   logic [11:0] full_code;
   logic [11:0] pre_code;

   assign full_code = cwte_pkg::FULL_BASE + 12'(mid_ff);
   assign pre_code  = cwte_pkg::PRE_BASE + 12'(mid_ff);

   always_ff @(posedge clock) begin
      if (ctl.set_top || ctl.set_none) begin
         cur_nib_ff <= ctl.set_top ? cwte_pkg::TOP_NIB : cwte_pkg::PAD_NIB;
         cur_nb_ff  <= 3'd0;
      end else if (ctl.set_full) begin
         cur_nib_ff  <= full_code[11:8];
         cur_b_ff[0] <= full_code[7:0];
         cur_nb_ff   <= 3'd1;
      end else if (ctl.set_pre) begin
         cur_nib_ff  <= pre_code[11:8];
         cur_b_ff[0] <= pre_code[7:0];
         cur_b_ff[1] <= key_ff[7:0];
         cur_nb_ff   <= 3'd2;
      end else if (ctl.set_lit) begin
         cur_nib_ff  <= cwte_pkg::LIT_NIB;
         cur_b_ff[0] <= key_ff[7:0];
         cur_b_ff[1] <= key_ff[15:8];
         cur_b_ff[2] <= key_ff[23:16];
         cur_b_ff[3] <= key_ff[31:24];
         cur_nb_ff   <= 3'd4;
      end
   end

   // Pair holding and emission buffer.
   logic       pair_half_ff;
   logic [3:0] held_nib_ff;
   logic [7:0] held_b_ff [4];
   logic [2:0] held_cnt_ff;
   logic [7:0] emit_ff [cwte_pkg::EmitDepth];
   logic [3:0] emit_cnt_ff;
   logic [7:0] pack [cwte_pkg::EmitDepth];
   logic [3:0] pos;
   logic       out_free;

   always_comb begin
      pos = '0;
      for (int k = 0; k < cwte_pkg::EmitDepth; k++) begin
         pack[k] = 8'h00;
      end
      pack[0] = {held_nib_ff, cur_nib_ff};
      for (int k = 0; k < 4; k++) begin
         pack[k + 1] = held_b_ff[k];
      end
      // Data bytes of the second word follow right after the held ones.
      for (int j = 0; j < 4; j++) begin
         pos = 4'd1 + {1'b0, held_cnt_ff} + 4'(j);
         if (3'(j) < cur_nb_ff) begin
            pack[pos] = cur_b_ff[j];
         end
      end
   end

   assign out_free = !rsp_tvalid || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_half_ff <= 1'b0;
         held_nib_ff  <= '0;
         held_cnt_ff  <= '0;
         emit_cnt_ff  <= '0;
      end else if (ctl.finish) begin
         if (pair_half_ff) begin
            pair_half_ff <= 1'b0;
            held_nib_ff  <= '0;
            held_cnt_ff  <= '0;
            emit_cnt_ff  <= 4'd1 + {1'b0, held_cnt_ff} + {1'b0, cur_nb_ff};
         end else begin
            pair_half_ff <= 1'b1;
            held_nib_ff  <= cur_nib_ff;
            held_cnt_ff  <= cur_nb_ff;
         end
      end else if (ctl.pop) begin
         emit_cnt_ff <= emit_cnt_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         if (pair_half_ff) begin
            emit_ff <= pack;
         end else begin
            held_b_ff <= cur_b_ff;
         end
      end else if (ctl.pop) begin
         for (int k = 0; k < cwte_pkg::EmitDepth - 1; k++) begin
            emit_ff[k] <= emit_ff[k + 1];
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid <= 1'b0;
      end else if (ctl.pop) begin
         rsp_tvalid <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.pop) begin
         rsp_byte <= emit_ff[0];
         rsp_last <= (emit_cnt_ff == 4'd1);
      end
   end

   assign stat.top_eq    = (key_ff == top_ff);
   assign stat.hit       = active && probe_eq;
   assign stat.miss      = !active;
   assign stat.pair_half = pair_half_ff;
   assign stat.out_free  = out_free;
   assign stat.last_byte = (emit_cnt_ff == 4'd1);

endmodule

// ----- design/code_word_table_encoder_top.sv -----
// ----------------------------------------------------------------------------
// code_word_table_encoder_top: table driven instruction word compressor
// Codes 32-bit words against a full-word table and a 24-bit prefix table and
// emits control bytes with the data bytes of each word pair.
// ----------------------------------------------------------------------------
// A table load is written straight from the input. An encode beat is
// accepted, checked against the top value and then binary searched in the
// full-word table and, on a miss, in the prefix table, one probe per cycle,
// since each table has a single read port; then the word is paired. The
// second word of a pair and an end of stream beat then emit 1 to 9 bytes at
// one byte per cycle while the receiver is ready, from the output register,
// which frees the input as soon as the last byte is loaded. The tables are
// not cleared at reset; entries must be loaded before they are searched.
module code_word_table_encoder_top #(
   parameter int TableEntries = cwte_pkg::TableEntriesDef
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] word, [42:32] entry_index, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   // Configuration port.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wr_data
);

   cwte_pkg::ctl_type  ctl;
   cwte_pkg::stat_type stat;
   cwte_pkg::cmd_type  req_command;

   assign req_command = cwte_pkg::cmd_type'(req_tuser);

   cwte_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_command (req_command),
      .req_tready  (req_tready),
      .stat        (stat),
      .ctl         (ctl)
   );

   cwte_dp #(
      .TableEntries (TableEntries)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data),
      .word        (req_tdata[31:0]),
      .entry_index (req_tdata[42:32]),
      .ctl         (ctl),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_byte    (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

   // A search is never both found and exhausted.
   assert property (@(posedge clock) disable iff (reset) !(stat.hit && stat.miss))
      else $error("search reports hit and miss together");

   // A byte is only moved into the output register when it is free.
   assert property (@(posedge clock) disable iff (reset) ctl.pop |-> stat.out_free)
      else $error("output register overwritten");

   // An accepted encode beat blocks the input while it is coded.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_command == cwte_pkg::CMD_ENCODE) |=> !req_tready)
      else $error("input taken during encode");

endmodule

// ----- sim/code_word_table_encoder_top_test.sv -----
// ----------------------------------------------------------------------------
// code_word_table_encoder_top_test: self-checking bench for the word encoder
// Loads the low part and the middle entry of both code tables with sorted
// entries, runs a directed table of beats and then random encode, load and
// end-of-stream traffic under several configurations and flow-control
// patterns. Every output byte is checked against the typed bytes of a directed
// row or a behavioral model of the pairing and table coding kept here.
// ----------------------------------------------------------------------------
module code_word_table_encoder_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TableEntries   = cwte_pkg::TableEntriesDef;
   localparam int FillEntries    = 32;
   localparam int MidEntry       = TableEntries / 2;
   localparam int ClockPeriod    = 10;
   localparam int ResetCycles    = 6;
   localparam int SettleCycles   = 64;
   localparam int HoldCycles     = 400;
   localparam int RandomPhases   = 8;
   localparam int RandomPerPhase = 17;
   localparam int TimeoutCycles  = 500_000;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_CONFIG,
      ROW_FILL
   } row_kind_type;

   typedef enum logic [1:0] {
      SRC_LITERAL,
      SRC_FULL,
      SRC_PREFIX,
      SRC_FULL_HI
   } word_src_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef enum logic [1:0] {
      KIND_TOP,
      KIND_FULL,
      KIND_PREFIX,
      KIND_LITERAL
   } code_kind_type;

   typedef struct packed {
      logic [31:0] top;
      logic [10:0] full_count;
      logic [10:0] prefix_count;
      logic        swap;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_beat_type;

   // typed_n of -1 leaves the expected bytes to the model.
   typedef struct packed {
      row_kind_type      kind;
      cwte_pkg::cmd_type cmd;
      word_src_type      src;
      logic [31:0]       word;
      logic [10:0]       idx;
      cfg_type           cfg;
      int                typed_n;
      logic [0:8][7:0]   typed;
   } row_type;

   localparam cfg_type NoCfg = '0;
   localparam int NumRows = 31;

   row_type directed_rows [0:NumRows-1] = '{
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0000_0000, 11'd0, NoCfg, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h1234_5678, 11'd0, NoCfg, 5,
        {8'h01, 8'h78, 8'h56, 8'h34, 8'h12, 32'd0}},
      '{ROW_ITEM, cwte_pkg::CMD_END, SRC_LITERAL, 32'h0000_0000, 11'd0, NoCfg, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'hFFFF_FFFF, 11'h7FF, NoCfg, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_END, SRC_LITERAL, 32'hFFFF_FFFF, 11'h7FF, NoCfg, 5,
        {8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'd0}},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0000_0000, 11'd0, NoCfg, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_END, SRC_LITERAL, 32'h0000_0000, 11'd0, NoCfg, 1,
        {8'h00, 64'd0}},
      '{ROW_ITEM, cwte_pkg::CMD_LOAD_FULL, SRC_LITERAL, 32'h0000_0000, 11'h7FF, NoCfg, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_LOAD_PRE, SRC_LITERAL, 32'hFFFF_FFFF, 11'd1792, NoCfg, 0, '0},
      '{ROW_CONFIG, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0, 11'd0,
        '{32'h0000_0000, 11'd0, 11'd0, 1'b1}, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h1234_5678, 11'd0, NoCfg, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0000_0000, 11'd0, NoCfg, 5,
        {8'h10, 8'h12, 8'h34, 8'h56, 8'h78, 32'd0}},
      '{ROW_FILL, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0, 11'd0, NoCfg, 0, '0},
      // Counts above the table size saturate, so the first probe of a search
      // lands on the middle entry.
      '{ROW_CONFIG, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0, 11'd0,
        '{32'hFFFF_FFFF, 11'd2047, 11'd1792, 1'b0}, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_FULL, 32'h0, 11'(MidEntry), NoCfg, -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'hFFFF_FFFF, 11'd0, NoCfg, -1, '0},
      '{ROW_CONFIG, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0, 11'd0,
        '{32'h5A5A_5A5A, 11'd0, 11'd2047, 1'b1}, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_PREFIX, 32'h0000_003C, 11'(MidEntry), NoCfg,
        -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_END, SRC_LITERAL, 32'h0, 11'd0, NoCfg, -1, '0},
      '{ROW_CONFIG, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0, 11'd0,
        '{32'hFFFF_FFFF, 11'(FillEntries), 11'(FillEntries), 1'b0}, 0, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_FULL, 32'h0, 11'd0, NoCfg, -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_FULL, 32'h0, 11'(FillEntries - 1), NoCfg,
        -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_PREFIX, 32'h0000_0000, 11'd0, NoCfg, -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_PREFIX, 32'h0000_00FF, 11'(FillEntries - 1),
        NoCfg, -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'hFFFF_FFFF, 11'd0, NoCfg, -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'h0000_0000, 11'd0, NoCfg, -1, '0},
      // A word present in both tables must take the full-word code.
      '{ROW_ITEM, cwte_pkg::CMD_LOAD_PRE, SRC_FULL_HI, 32'hC300_0000, 11'd5, NoCfg, -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_FULL, 32'h0, 11'd5, NoCfg, -1, '0},
      // The top value wins even when the full-word table also holds it.
      '{ROW_ITEM, cwte_pkg::CMD_LOAD_FULL, SRC_LITERAL, 32'hFFFF_FFFF, 11'(FillEntries - 1),
        NoCfg, -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_ENCODE, SRC_LITERAL, 32'hFFFF_FFFF, 11'd0, NoCfg, -1, '0},
      '{ROW_ITEM, cwte_pkg::CMD_END, SRC_LITERAL, 32'h0, 11'd0, NoCfg, -1, '0}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = cwte_pkg::CMD_ENCODE;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_addr    = cwte_pkg::REG_TOP_VALUE;
   logic [31:0] csr_wr_data = '0;

   // Model state.
   logic [31:0]     full_mirror [TableEntries];
   logic [23:0]     prefix_mirror [TableEntries];
   cfg_type         cur_cfg = NoCfg;
   logic            pair_open = 1'b0;
   logic [3:0]      held_nibble = '0;
   logic [0:3][7:0] held_data = '0;
   int              held_count = 0;

   byte_beat_type   predicted_bytes [$];
   byte_beat_type   expected_bytes [$];

   idle_mode_type   idle_mode = IDLE_NONE;
   int              hold_requests = 0;
   int              hold_seen = 0;
   int              hold_left = 0;
   int              error_count = 0;
   int              beats_sent = 0;
   int              loads_sent = 0;
   int              bytes_checked = 0;
   int              coded_words [4] = '{0, 0, 0, 0};

   code_word_table_encoder_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   function automatic logic [31:0] byte_reverse(logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

   // Input order of a word that must reach the coder as the given value.
   function automatic logic [31:0] to_input_order(logic [31:0] w);
      return cur_cfg.swap ? byte_reverse(w) : w;
   endfunction

   function automatic int live_entries(logic [10:0] count);
      return (count > TableEntries) ? TableEntries : int'(count);
   endfunction

   function automatic int table_search(logic prefix_side, logic [31:0] key,
                                       logic [10:0] count);
      int          lo;
      int          hi;
      int          mid;
      logic [31:0] probe;
      lo = 0;
      hi = live_entries(count);
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         probe = prefix_side ? {8'd0, prefix_mirror[mid]} : full_mirror[mid];
         if (probe == key) begin
            return mid;
         end
         if (probe < key) begin
            lo = mid + 1;
         end else begin
            hi = mid;
         end
      end
      return -1;
   endfunction

   task automatic close_pair(logic [3:0] nib, logic [0:3][7:0] data, int count);
      int            k;
      byte_beat_type tail;
      predicted_bytes.push_back('{data: {held_nibble, nib}, last: 1'b0});
      for (k = 0; k < held_count; k++) begin
         predicted_bytes.push_back('{data: held_data[k], last: 1'b0});
      end
      for (k = 0; k < count; k++) begin
         predicted_bytes.push_back('{data: data[k], last: 1'b0});
      end
      tail = predicted_bytes.pop_back();
      tail.last = 1'b1;
      predicted_bytes.push_back(tail);
      pair_open = 1'b0;
      held_nibble = '0;
      held_count = 0;
   endtask

   task automatic predict_beat(cwte_pkg::cmd_type c, logic [31:0] w, logic [10:0] idx);
      logic [31:0]     v;
      logic [3:0]      nib;
      logic [0:3][7:0] data;
      logic [11:0]     code;
      int              count;
      int              hit;
      case (c)
         cwte_pkg::CMD_LOAD_FULL: begin
            if (idx < TableEntries) full_mirror[idx] = w;
         end
         cwte_pkg::CMD_LOAD_PRE: begin
            if (idx < TableEntries) prefix_mirror[idx] = w[23:0];
         end
         cwte_pkg::CMD_END: begin
            if (pair_open) close_pair(cwte_pkg::PAD_NIB, '0, 0);
         end
         default: begin
            v = to_input_order(w);
            data = '0;
            count = 0;
            if (v == cur_cfg.top) begin
               nib = cwte_pkg::TOP_NIB;
               coded_words[KIND_TOP]++;
            end else begin
               hit = table_search(1'b0, v, cur_cfg.full_count);
               if (hit >= 0) begin
                  code = cwte_pkg::FULL_BASE + 12'(hit);
                  nib = code[11:8];
                  data[0] = code[7:0];
                  count = 1;
                  coded_words[KIND_FULL]++;
               end else begin
                  hit = table_search(1'b1, {8'd0, v[31:8]}, cur_cfg.prefix_count);
                  if (hit >= 0) begin
                     code = cwte_pkg::PRE_BASE + 12'(hit);
                     nib = code[11:8];
                     data[0] = code[7:0];
                     data[1] = v[7:0];
                     count = 2;
                     coded_words[KIND_PREFIX]++;
                  end else begin
                     nib = cwte_pkg::LIT_NIB;
                     data = {v[7:0], v[15:8], v[23:16], v[31:24]};
                     count = 4;
                     coded_words[KIND_LITERAL]++;
                  end
               end
            end
            if (!pair_open) begin
               held_nibble = nib;
               held_data = data;
               held_count = count;
               pair_open = 1'b1;
            end else begin
               close_pair(nib, data, count);
            end
         end
      endcase
   endtask

   function automatic bit sender_rests();
      case (idle_mode)
         IDLE_SENDER: return $urandom_range(99) < 49;
         IDLE_BOTH:   return $urandom_range(99) < 24;
         default:     return 1'b0;
      endcase
   endfunction

   // Starts and ends on a falling edge; valid stays high for a following beat.
   task automatic send_beat(cwte_pkg::cmd_type c, logic [31:0] w, logic [10:0] idx,
                            int typed_n, logic [0:8][7:0] typed);
      int k;
      while (sender_rests()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= c;
      req_tdata <= {5'd0, idx, w};
      do @(posedge clock); while (!req_tready);
      predicted_bytes.delete();
      predict_beat(c, w, idx);
      if (typed_n < 0) begin
         for (k = 0; k < predicted_bytes.size(); k++) begin
            expected_bytes.push_back(predicted_bytes[k]);
         end
      end else begin
         for (k = 0; k < typed_n; k++) begin
            expected_bytes.push_back('{data: typed[k], last: (k == typed_n - 1)});
         end
      end
      beats_sent++;
      if (c == cwte_pkg::CMD_LOAD_FULL || c == cwte_pkg::CMD_LOAD_PRE) loads_sent++;
      @(negedge clock);
   endtask

   // An encode beat that yields no byte may still be searching when the
   // queue runs dry, so the settle time covers two full binary searches.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic write_config(cfg_type c);
      wait_for_drain();
      csr_wr_en <= 1'b1;
      csr_addr <= cwte_pkg::REG_TOP_VALUE;
      csr_wr_data <= c.top;
      @(negedge clock);
      csr_addr <= cwte_pkg::REG_FULL_COUNT;
      csr_wr_data <= {21'd0, c.full_count};
      @(negedge clock);
      csr_addr <= cwte_pkg::REG_PREFIX_COUNT;
      csr_wr_data <= {21'd0, c.prefix_count};
      @(negedge clock);
      csr_addr <= cwte_pkg::REG_BYTE_SWAP;
      csr_wr_data <= {31'd0, c.swap};
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_cfg = c;
   endtask

   // Entries rise with their index, so the loaded part of each table is
   // sorted. The middle entry is loaded too, since it is the first probe of
   // a search over a full-size table.
   task automatic load_sorted_tables();
      int i;
      int slot;
      for (i = 0; i <= FillEntries; i++) begin
         slot = (i < FillEntries) ? i : MidEntry;
         send_beat(cwte_pkg::CMD_LOAD_FULL, {11'(slot), 21'($urandom)}, 11'(slot), -1, '0);
      end
      for (i = 0; i <= FillEntries; i++) begin
         slot = (i < FillEntries) ? i : MidEntry;
         send_beat(cwte_pkg::CMD_LOAD_PRE, {8'($urandom), 11'(slot), 13'($urandom)},
                   11'(slot), -1, '0);
      end
   endtask

   function automatic logic [31:0] row_word(row_type row);
      case (row.src)
         SRC_FULL:    return to_input_order(full_mirror[row.idx]);
         SRC_PREFIX:  return to_input_order({prefix_mirror[row.idx], row.word[7:0]});
         SRC_FULL_HI: return {row.word[31:24], full_mirror[row.idx][31:8]};
         default:     return row.word;
      endcase
   endfunction

   // Counts stay within the loaded part of the tables.
   function automatic logic [10:0] random_count();
      case ($urandom_range(3))
         0:       return 11'd0;
         1:       return 11'd1;
         2:       return 11'($urandom_range(2, 16));
         default: return 11'($urandom_range(17, FillEntries));
      endcase
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      case ($urandom_range(3))
         0:       c.top = 32'h0000_0000;
         1:       c.top = 32'hFFFF_FFFF;
         2:       c.top = full_mirror[$urandom_range(0, FillEntries - 1)];
         default: c.top = $urandom;
      endcase
      c.full_count = random_count();
      c.prefix_count = random_count();
      c.swap = 1'($urandom_range(1));
      return c;
   endfunction

   // Mostly words that hit one of the coding paths, plus a few loads that
   // may leave the tables out of order, and stream ends.
   task automatic send_random_item();
      int          pick;
      int          full_live;
      int          prefix_live;
      logic [31:0] target;
      logic [10:0] idx;
      full_live = live_entries(cur_cfg.full_count);
      prefix_live = live_entries(cur_cfg.prefix_count);
      pick = $urandom_range(99);
      idx = 11'($urandom_range(0, 2047));
      target = $urandom;
      if (pick < 7) begin
         send_beat(cwte_pkg::CMD_END, target, idx, -1, '0);
      end else if (pick < 13) begin
         if ($urandom_range(1) == 0) begin
            if ($urandom_range(2) != 0) target = {idx, target[20:0]};
            send_beat(cwte_pkg::CMD_LOAD_FULL, target, idx, -1, '0);
         end else begin
            if ($urandom_range(2) != 0) target = {target[31:24], idx, target[12:0]};
            send_beat(cwte_pkg::CMD_LOAD_PRE, target, idx, -1, '0);
         end
      end else begin
         if (pick < 27) begin
            target = cur_cfg.top;
         end else if (pick < 52 && full_live > 0) begin
            target = full_mirror[$urandom_range(0, full_live - 1)];
         end else if (pick < 74 && prefix_live > 0) begin
            target = {prefix_mirror[$urandom_range(0, prefix_live - 1)], target[7:0]};
         end
         send_beat(cwte_pkg::CMD_ENCODE, to_input_order(target), idx, -1, '0);
      end
   endtask

   task automatic report_failure(string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR at %0t ns: %s", $time, msg);
   endtask

   // Receiver: random stalls per idle mode, plus a long hold-off on request.
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (idle_mode == IDLE_RECEIVER) begin
         rsp_tready <= ($urandom_range(99) >= 49);
      end else if (idle_mode == IDLE_BOTH) begin
         rsp_tready <= ($urandom_range(99) >= 24);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_output
      byte_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         bytes_checked++;
         if (expected_bytes.size() == 0) begin
            report_failure($sformatf("unexpected byte %02h last %0b", rsp_tdata, rsp_tlast));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
               report_failure($sformatf("byte %02h last %0b, expected byte %02h last %0b",
                                        rsp_tdata, rsp_tlast, want.data, want.last));
            end
         end
      end
   end

   initial begin
      #(TimeoutCycles * ClockPeriod);
      $display("Timed out with %0d expected bytes outstanding.", expected_bytes.size());
      $display("code_word_table_encoder_top: mismatch");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int n;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_FILL:   load_sorted_tables();
            ROW_CONFIG: write_config(directed_rows[r].cfg);
            default: begin
               send_beat(directed_rows[r].cmd, row_word(directed_rows[r]),
                         directed_rows[r].idx, directed_rows[r].typed_n,
                         directed_rows[r].typed);
            end
         endcase
      end
      for (phase = 0; phase < RandomPhases; phase++) begin
         write_config(random_config());
         idle_mode = idle_mode_type'(phase % 4);
         // The output side holds off while words keep coming, so the block
         // backs up and stalls its input.
         if (phase == 4) hold_requests++;
         for (n = 0; n < RandomPerPhase; n++) send_random_item();
      end
      wait_for_drain();
      $display("Ran %0d input beats (%0d table loads) and checked %0d output bytes.",
               beats_sent, loads_sent, bytes_checked);
      $display("Words coded: %0d top value, %0d full-table, %0d prefix-table, %0d literal.",
               coded_words[KIND_TOP], coded_words[KIND_FULL],
               coded_words[KIND_PREFIX], coded_words[KIND_LITERAL]);
      if (error_count == 0) begin
         $display("code_word_table_encoder_top: match");
      end else begin
         $display("code_word_table_encoder_top: mismatch");
      end
      $finish;
   end

endmodule

// ----- code_word_table_encoder_top.f -----
design/cwte_pkg.sv
design/cwte_ctrl.sv
design/cwte_dp.sv
design/code_word_table_encoder_top.sv
sim/code_word_table_encoder_top_test.sv
